/* src/bop_pkg.sv */
// bop_pkg: shared types and constants for the band overlap projector
// used by bop_ctrl, bop_datapath and band_overlap_projector; no dependencies
package bop_pkg;

  // fixed field and state widths
  localparam int unsigned AccBits   = 40;
  localparam int unsigned OvlBits   = 32;
  localparam int unsigned TotalBits = 48;
  localparam int unsigned OccBits   = 16;
  localparam int unsigned WgtBits   = 16;
  localparam int unsigned MagShift  = 28;
  localparam int unsigned WgtShift  = 16;
  // squared magnitude after the shift, and its weighted contribution
  localparam int unsigned MagBits   = 2 * OvlBits - MagShift;

  // threshold after reset, 0.5 in Q2.14
  localparam logic [OccBits-1:0] ThreshReset = 16'd8192;

  // commands from controller to datapath
  typedef struct packed {
    logic load;    // capture an accepted transaction
    logic mul;     // register the four coefficient products
    logic acc;     // update the accumulators
    logic ovl;     // saturate accumulators to the overlap
    logic sq;      // square both overlap parts
    logic mag;     // sum and scale squared magnitude
    logic wgt;     // apply the k-point weight
    logic finish;  // update totals, load output register, clear accumulators
  } bop_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic last;    // captured item closes a band and k-point pair
  } bop_status_t;

endpackage

/* src/band_overlap_projector.sv */
// band_overlap_projector: top level, complex conjugate dot product with weighted totals
// instantiates bop_ctrl and bop_datapath; depends on bop_pkg
// an item that is not the last wave passes through accept, product stage and accumulate
// a last-wave item goes on to its result through the serial chain of saturate,
// square, scale, weight and total update stages, plus any wait for the output register
// reset (rst_ni, asynchronous, active low) clears accumulators and totals and sets the
// threshold to 0.5; the output register lets a new transaction in while a result waits
module band_overlap_projector import bop_pkg::*; #(
  parameter int unsigned COEF_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [OccBits-1:0]          cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic signed [COEF_BITS-1:0] proj_re_i,
  input  logic signed [COEF_BITS-1:0] proj_im_i,
  input  logic signed [COEF_BITS-1:0] ref_re_i,
  input  logic signed [COEF_BITS-1:0] ref_im_i,
  input  logic                        last_wave_i,
  input  logic [OccBits-1:0]          occupancy_i,
  input  logic [WgtBits-1:0]          kpoint_weight_i,
  input  logic                        clear_totals_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic signed [OvlBits-1:0]   overlap_re_o,
  output logic signed [OvlBits-1:0]   overlap_im_o,
  output logic [TotalBits-1:0]        valence_total_o,
  output logic [TotalBits-1:0]        conduction_total_o
);

  bop_cmd_t    cmd;
  bop_status_t status;

  // sequencer
  bop_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // arithmetic and state
  bop_datapath #(
    .COEF_BITS (COEF_BITS)
  ) u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .status_o           (status),
    .cfg_we_i           (cfg_we_i),
    .cfg_data_i         (cfg_data_i),
    .proj_re_i          (proj_re_i),
    .proj_im_i          (proj_im_i),
    .ref_re_i           (ref_re_i),
    .ref_im_i           (ref_im_i),
    .last_wave_i        (last_wave_i),
    .occupancy_i        (occupancy_i),
    .kpoint_weight_i    (kpoint_weight_i),
    .clear_totals_i     (clear_totals_i),
    .overlap_re_o       (overlap_re_o),
    .overlap_im_o       (overlap_im_o),
    .valence_total_o    (valence_total_o),
    .conduction_total_o (conduction_total_o)
  );

endmodule

/* src/bop_ctrl.sv */
// bop_ctrl: sequencer for the band overlap projector
// depends on bop_pkg for the command and status structs
module bop_ctrl import bop_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  input  bop_status_t status_i,
  output bop_cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    StIdle,
    StMul,
    StAcc,
    StOvl,
    StSq,
    StMag,
    StWgt,
    StFin
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  // output register can take a new result this cycle
  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StMul;
        end
      end
      StMul: begin
        cmd_o.mul = 1'b1;
        state_d   = StAcc;
      end
      StAcc: begin
        cmd_o.acc = 1'b1;
        state_d   = status_i.last ? StOvl : StIdle;
      end
      StOvl: begin
        cmd_o.ovl = 1'b1;
        state_d   = StSq;
      end
      StSq: begin
        cmd_o.sq = 1'b1;
        state_d  = StMag;
      end
      StMag: begin
        cmd_o.mag = 1'b1;
        state_d   = StWgt;
      end
      StWgt: begin
        cmd_o.wgt = 1'b1;
        state_d   = StFin;
      end
      StFin: begin
        if (out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // result valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.finish) out_valid_d = 1'b1;
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

/* src/bop_datapath.sv */
// bop_datapath: multiply-accumulate, overlap saturation and weighted totals
// depends on bop_pkg for widths and the command and status structs
module bop_datapath import bop_pkg::*; #(
  parameter int unsigned COEF_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  bop_cmd_t                    cmd_i,
  output bop_status_t                 status_o,
  input  logic                        cfg_we_i,
  input  logic [OccBits-1:0]          cfg_data_i,
  input  logic signed [COEF_BITS-1:0] proj_re_i,
  input  logic signed [COEF_BITS-1:0] proj_im_i,
  input  logic signed [COEF_BITS-1:0] ref_re_i,
  input  logic signed [COEF_BITS-1:0] ref_im_i,
  input  logic                        last_wave_i,
  input  logic [OccBits-1:0]          occupancy_i,
  input  logic [WgtBits-1:0]          kpoint_weight_i,
  input  logic                        clear_totals_i,
  output logic signed [OvlBits-1:0]   overlap_re_o,
  output logic signed [OvlBits-1:0]   overlap_im_o,
  output logic [TotalBits-1:0]        valence_total_o,
  output logic [TotalBits-1:0]        conduction_total_o
);

  localparam int unsigned ProdBits = 2 * COEF_BITS;
  localparam int unsigned PairBits = ProdBits + 1;
  localparam int unsigned SumBits  = ((PairBits > AccBits) ? PairBits : AccBits) + 1;
  localparam int unsigned WprBits  = MagBits + WgtBits;

  localparam logic signed [SumBits-1:0] AccMax =
    {{(SumBits - AccBits + 1){1'b0}}, {(AccBits - 1){1'b1}}};
  localparam logic signed [SumBits-1:0] AccMin =
    {{(SumBits - AccBits + 1){1'b1}}, {(AccBits - 1){1'b0}}};
  localparam logic signed [AccBits-1:0] OvlMax =
    {{(AccBits - OvlBits + 1){1'b0}}, {(OvlBits - 1){1'b1}}};
  localparam logic signed [AccBits-1:0] OvlMin =
    {{(AccBits - OvlBits + 1){1'b1}}, {(OvlBits - 1){1'b0}}};
  localparam logic [TotalBits:0] TotalMax = {1'b0, {TotalBits{1'b1}}};

  logic [OccBits-1:0]          thresh_q;
  logic signed [COEF_BITS-1:0] pr_q, pi_q, rr_q, ri_q;
  logic                        last_q;
  logic [OccBits-1:0]          occ_q;
  logic [WgtBits-1:0]          wgt_q;
  logic signed [ProdBits-1:0]  prr_q, pii_q, pir_q, pri_q;
  logic signed [AccBits-1:0]   acc_re_q, acc_im_q;
  logic signed [OvlBits-1:0]   ovl_re_q, ovl_im_q;
  logic [2*OvlBits-1:0]        sq_re_q, sq_im_q;
  logic [MagBits-1:0]          mag_q, contrib_q;
  logic [TotalBits-1:0]        valence_q, conduction_q;

  logic signed [PairBits-1:0]  pair_re, pair_im;
  logic signed [SumBits-1:0]   sum_re, sum_im;
  logic signed [AccBits-1:0]   acc_re_d, acc_im_d;
  logic signed [OvlBits-1:0]   ovl_re_d, ovl_im_d;
  logic [OvlBits:0]            neg_re, neg_im;
  logic [OvlBits-1:0]          abs_re, abs_im;
  logic [2*OvlBits-1:0]        mag_sum;
  logic [WprBits-1:0]          wprod;
  logic                        is_valence;
  logic [TotalBits-1:0]        base_total, sat_total;
  logic [TotalBits:0]          add_total;
  logic [TotalBits-1:0]        valence_d, conduction_d;

  assign status_o.last = last_q;

  // threshold register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= ThreshReset;
    end else if (cfg_we_i) begin
      thresh_q <= cfg_data_i;
    end
  end

  // input capture and coefficient products
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      pr_q   <= proj_re_i;
      pi_q   <= proj_im_i;
      rr_q   <= ref_re_i;
      ri_q   <= ref_im_i;
      last_q <= last_wave_i;
      occ_q  <= occupancy_i;
      wgt_q  <= kpoint_weight_i;
    end
    if (cmd_i.mul) begin
      prr_q <= pr_q * rr_q;
      pii_q <= pi_q * ri_q;
      pir_q <= pi_q * rr_q;
      pri_q <= pr_q * ri_q;
    end
  end

  // accumulate proj times conj(ref) with saturation at the accumulator limits
  always_comb begin
    pair_re = PairBits'(prr_q) + PairBits'(pii_q);
    pair_im = PairBits'(pir_q) - PairBits'(pri_q);
    sum_re  = SumBits'(acc_re_q) + SumBits'(pair_re);
    sum_im  = SumBits'(acc_im_q) + SumBits'(pair_im);
    if (sum_re > AccMax)      acc_re_d = AccMax[AccBits-1:0];
    else if (sum_re < AccMin) acc_re_d = AccMin[AccBits-1:0];
    else                      acc_re_d = sum_re[AccBits-1:0];
    if (sum_im > AccMax)      acc_im_d = AccMax[AccBits-1:0];
    else if (sum_im < AccMin) acc_im_d = AccMin[AccBits-1:0];
    else                      acc_im_d = sum_im[AccBits-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_re_q <= '0;
      acc_im_q <= '0;
    end else if (cmd_i.finish) begin
      acc_re_q <= '0;
      acc_im_q <= '0;
    end else if (cmd_i.acc) begin
      acc_re_q <= acc_re_d;
      acc_im_q <= acc_im_d;
    end
  end

  // overlap saturation and magnitude
  always_comb begin
    if (acc_re_q > OvlMax)      ovl_re_d = OvlMax[OvlBits-1:0];
    else if (acc_re_q < OvlMin) ovl_re_d = OvlMin[OvlBits-1:0];
    else                        ovl_re_d = acc_re_q[OvlBits-1:0];
    if (acc_im_q > OvlMax)      ovl_im_d = OvlMax[OvlBits-1:0];
    else if (acc_im_q < OvlMin) ovl_im_d = OvlMin[OvlBits-1:0];
    else                        ovl_im_d = acc_im_q[OvlBits-1:0];
    neg_re  = -{ovl_re_q[OvlBits-1], ovl_re_q};
    neg_im  = -{ovl_im_q[OvlBits-1], ovl_im_q};
    abs_re  = ovl_re_q[OvlBits-1] ? neg_re[OvlBits-1:0] : ovl_re_q;
    abs_im  = ovl_im_q[OvlBits-1] ? neg_im[OvlBits-1:0] : ovl_im_q;
    mag_sum = sq_re_q + sq_im_q;
    wprod   = mag_q * wgt_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ovl) begin
      ovl_re_q <= ovl_re_d;
      ovl_im_q <= ovl_im_d;
    end
    if (cmd_i.sq) begin
      sq_re_q <= abs_re * abs_re;
      sq_im_q <= abs_im * abs_im;
    end
    if (cmd_i.mag) begin
      mag_q <= mag_sum[2*OvlBits-1:MagShift];
    end
    if (cmd_i.wgt) begin
      contrib_q <= wprod[WprBits-1:WgtShift];
    end
  end

  // saturating update of the selected total
  always_comb begin
    is_valence   = occ_q > thresh_q;
    base_total   = is_valence ? valence_q : conduction_q;
    add_total    = {1'b0, base_total} + (TotalBits + 1)'(contrib_q);
    sat_total    = (add_total > TotalMax) ? TotalMax[TotalBits-1:0]
                                          : add_total[TotalBits-1:0];
    valence_d    = is_valence ? sat_total : valence_q;
    conduction_d = is_valence ? conduction_q : sat_total;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valence_q    <= '0;
      conduction_q <= '0;
    end else if (cmd_i.load && clear_totals_i) begin
      valence_q    <= '0;
      conduction_q <= '0;
    end else if (cmd_i.finish) begin
      valence_q    <= valence_d;
      conduction_q <= conduction_d;
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      overlap_re_o       <= ovl_re_q;
      overlap_im_o       <= ovl_im_q;
      valence_total_o    <= valence_d;
      conduction_total_o <= conduction_d;
    end
  end

endmodule

/* tb/sv/band_overlap_projector_monitor.sv */
// band_overlap_projector_monitor: watches both channels of the band overlap projector,
// predicts each overlap result and compares it field by field against the block
// depends on bop_pkg for field widths, shifts and the threshold reset value
`timescale 1ns / 100ps

module band_overlap_projector_monitor import bop_pkg::*; #(
  parameter int unsigned COEF_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [OccBits-1:0]          cfg_data_i,
  input  logic                        in_valid_i,
  input  logic                        in_ready_i,
  input  logic signed [COEF_BITS-1:0] proj_re_i,
  input  logic signed [COEF_BITS-1:0] proj_im_i,
  input  logic signed [COEF_BITS-1:0] ref_re_i,
  input  logic signed [COEF_BITS-1:0] ref_im_i,
  input  logic                        last_wave_i,
  input  logic [OccBits-1:0]          occupancy_i,
  input  logic [WgtBits-1:0]          kpoint_weight_i,
  input  logic                        clear_totals_i,
  input  logic                        out_valid_i,
  input  logic                        out_ready_i,
  input  logic signed [OvlBits-1:0]   overlap_re_i,
  input  logic signed [OvlBits-1:0]   overlap_im_i,
  input  logic [TotalBits-1:0]        valence_total_i,
  input  logic [TotalBits-1:0]        conduction_total_i,
  output int                          mismatch_count_o,
  output int                          pending_o,
  output int                          result_count_o
);

  typedef longint unsigned u64_t;

  // saturation limits of accumulators, overlap and totals
  localparam longint AccHi    = (longint'(1) << (AccBits - 1)) - 1;
  localparam longint AccLo    = -AccHi - 1;
  localparam longint OvlHi    = (longint'(1) << (OvlBits - 1)) - 1;
  localparam longint OvlLo    = -OvlHi - 1;
  localparam u64_t   TotalMax = (u64_t'(1) << TotalBits) - 1;

  typedef struct packed {
    logic signed [OvlBits-1:0] re;
    logic signed [OvlBits-1:0] im;
    logic [TotalBits-1:0]      valence;
    logic [TotalBits-1:0]      conduction;
  } overlap_t;

  // predicted block state
  logic [OccBits-1:0]   threshold_q;
  longint               acc_re_q;
  longint               acc_im_q;
  logic [TotalBits-1:0] valence_q;
  logic [TotalBits-1:0] conduction_q;

  overlap_t expected_overlaps[$];
  overlap_t oldest;

  function automatic longint clamp_to(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [TotalBits-1:0] add_saturating(logic [TotalBits-1:0] total,
                                                          u64_t add);
    u64_t s;
    s = u64_t'(total) + add;
    return TotalBits'((s > TotalMax) ? TotalMax : s);
  endfunction

  // fold one coefficient pair into the running overlap, close the band on last wave
  task automatic accumulate_wave(input logic signed [COEF_BITS-1:0] pr,
                                 input logic signed [COEF_BITS-1:0] pi,
                                 input logic signed [COEF_BITS-1:0] rr,
                                 input logic signed [COEF_BITS-1:0] ri,
                                 input logic last,
                                 input logic [OccBits-1:0] occ,
                                 input logic [WgtBits-1:0] wgt,
                                 input logic clr);
    longint   ore;
    longint   oim;
    u64_t     are;
    u64_t     aim;
    u64_t     mag;
    u64_t     contrib;
    overlap_t res;
    if (clr) begin
      valence_q    = '0;
      conduction_q = '0;
    end
    acc_re_q = clamp_to(acc_re_q + longint'(pr) * longint'(rr) + longint'(pi) * longint'(ri),
                        AccLo, AccHi);
    acc_im_q = clamp_to(acc_im_q + longint'(pi) * longint'(rr) - longint'(pr) * longint'(ri),
                        AccLo, AccHi);
    if (last) begin
      ore     = clamp_to(acc_re_q, OvlLo, OvlHi);
      oim     = clamp_to(acc_im_q, OvlLo, OvlHi);
      are     = u64_t'((ore < 0) ? -ore : ore);
      aim     = u64_t'((oim < 0) ? -oim : oim);
      mag     = (are * are + aim * aim) >> MagShift;
      contrib = (mag * u64_t'(wgt)) >> WgtShift;
      // strictly above the threshold is valence, equal counts as conduction
      if (occ > threshold_q) begin
        valence_q = add_saturating(valence_q, contrib);
      end else begin
        conduction_q = add_saturating(conduction_q, contrib);
      end
      acc_re_q       = 0;
      acc_im_q       = 0;
      res.re         = OvlBits'(ore);
      res.im         = OvlBits'(oim);
      res.valence    = valence_q;
      res.conduction = conduction_q;
      expected_overlaps.push_back(res);
    end
  endtask

  task automatic report_field(input string name, input longint expected, input longint actual);
    if (expected != actual) begin
      mismatch_count_o++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, expected, actual);
    end
  endtask

  // track writes and transactions on both channels
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q  = ThreshReset;
      acc_re_q     = 0;
      acc_im_q     = 0;
      valence_q    = '0;
      conduction_q = '0;
      expected_overlaps.delete();
      mismatch_count_o = 0;
      pending_o        = 0;
      result_count_o   = 0;
    end else begin
      // threshold register write
      if (cfg_we_i) begin
        threshold_q = cfg_data_i;
      end
      // input transaction
      if (in_valid_i && in_ready_i) begin
        accumulate_wave(proj_re_i, proj_im_i, ref_re_i, ref_im_i, last_wave_i,
                        occupancy_i, kpoint_weight_i, clear_totals_i);
      end
      // output transaction against the oldest prediction
      if (out_valid_i && out_ready_i) begin
        if (expected_overlaps.size() == 0) begin
          mismatch_count_o++;
          $display("%0t: unexpected result, expected none, actual %0d %0d %0d %0d", $time,
                   overlap_re_i, overlap_im_i, valence_total_i, conduction_total_i);
        end else begin
          oldest = expected_overlaps.pop_front();
          report_field("overlap_re", longint'(oldest.re), longint'(overlap_re_i));
          report_field("overlap_im", longint'(oldest.im), longint'(overlap_im_i));
          report_field("valence_total", longint'(oldest.valence), longint'(valence_total_i));
          report_field("conduction_total", longint'(oldest.conduction),
                       longint'(conduction_total_i));
          result_count_o++;
        end
      end
      pending_o = expected_overlaps.size();
    end
  end

endmodule

/* tb/sv/band_overlap_projector_tb.sv */
// band_overlap_projector_tb: drives coefficient bands and threshold settings into the
// band overlap projector and reports the verdict of band_overlap_projector_monitor
// depends on bop_pkg, band_overlap_projector and band_overlap_projector_monitor
`timescale 1ns / 100ps

module band_overlap_projector_tb;
  import bop_pkg::*;

  localparam int unsigned CoefBits     = 16;
  localparam int unsigned ResetCycles  = 12;
  localparam int unsigned StallCycles  = 300;
  localparam int unsigned SettleCycles = 16;
  localparam int unsigned PhaseItems   = 250;
  localparam int unsigned LongBandLen  = 280;
  localparam int unsigned CycleLimit   = 400000;

  typedef struct packed {
    logic signed [CoefBits-1:0] proj_re;
    logic signed [CoefBits-1:0] proj_im;
    logic signed [CoefBits-1:0] ref_re;
    logic signed [CoefBits-1:0] ref_im;
    logic                       last_wave;
    logic [OccBits-1:0]         occupancy;
    logic [WgtBits-1:0]         kpoint_weight;
    logic                       clear_totals;
  } wave_item_t;

  logic                       clk = 1'b0;
  logic                       rst_n;
  logic                       cfg_we;
  logic [OccBits-1:0]         cfg_data;
  logic                       in_valid;
  logic                       in_ready;
  logic signed [CoefBits-1:0] proj_re;
  logic signed [CoefBits-1:0] proj_im;
  logic signed [CoefBits-1:0] ref_re;
  logic signed [CoefBits-1:0] ref_im;
  logic                       last_wave;
  logic [OccBits-1:0]         occupancy;
  logic [WgtBits-1:0]         kpoint_weight;
  logic                       clear_totals;
  logic                       out_valid;
  logic                       out_ready;
  logic signed [OvlBits-1:0]  overlap_re;
  logic signed [OvlBits-1:0]  overlap_im;
  logic [TotalBits-1:0]       valence_total;
  logic [TotalBits-1:0]       conduction_total;

  int                 mismatches;
  int                 pending;
  int                 results;
  int                 cycles = 0;
  int                 items_sent;
  bit                 quiet_tail;
  bit                 stall_request;
  logic [OccBits-1:0] threshold_now;

  band_overlap_projector #(
    .COEF_BITS(CoefBits)
  ) dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_we_i          (cfg_we),
    .cfg_data_i        (cfg_data),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready),
    .proj_re_i         (proj_re),
    .proj_im_i         (proj_im),
    .ref_re_i          (ref_re),
    .ref_im_i          (ref_im),
    .last_wave_i       (last_wave),
    .occupancy_i       (occupancy),
    .kpoint_weight_i   (kpoint_weight),
    .clear_totals_i    (clear_totals),
    .out_valid_o       (out_valid),
    .out_ready_i       (out_ready),
    .overlap_re_o      (overlap_re),
    .overlap_im_o      (overlap_im),
    .valence_total_o   (valence_total),
    .conduction_total_o(conduction_total)
  );

  band_overlap_projector_monitor #(
    .COEF_BITS(CoefBits)
  ) overlap_mon (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_we_i          (cfg_we),
    .cfg_data_i        (cfg_data),
    .in_valid_i        (in_valid),
    .in_ready_i        (in_ready),
    .proj_re_i         (proj_re),
    .proj_im_i         (proj_im),
    .ref_re_i          (ref_re),
    .ref_im_i          (ref_im),
    .last_wave_i       (last_wave),
    .occupancy_i       (occupancy),
    .kpoint_weight_i   (kpoint_weight),
    .clear_totals_i    (clear_totals),
    .out_valid_i       (out_valid),
    .out_ready_i       (out_ready),
    .overlap_re_i      (overlap_re),
    .overlap_im_i      (overlap_im),
    .valence_total_i   (valence_total),
    .conduction_total_i(conduction_total),
    .mismatch_count_o  (mismatches),
    .pending_o         (pending),
    .result_count_o    (results)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("band_overlap_projector_tb: done, errors");
      $finish;
    end
  end

  function automatic wave_item_t make_wave(logic signed [CoefBits-1:0] pr,
                                           logic signed [CoefBits-1:0] pi,
                                           logic signed [CoefBits-1:0] rr,
                                           logic signed [CoefBits-1:0] ri,
                                           logic last, logic [OccBits-1:0] occ,
                                           logic [WgtBits-1:0] wgt, logic clr);
    wave_item_t w;
    w.proj_re       = pr;
    w.proj_im       = pi;
    w.ref_re        = rr;
    w.ref_im        = ri;
    w.last_wave     = last;
    w.occupancy     = occ;
    w.kpoint_weight = wgt;
    w.clear_totals  = clr;
    return w;
  endfunction

  // coefficients lean on the extremes and on small values
  function automatic logic signed [CoefBits-1:0] pick_coef();
    case ($urandom_range(0, 9))
      0:       return {1'b1, {(CoefBits - 1){1'b0}}};
      1:       return {1'b0, {(CoefBits - 1){1'b1}}};
      2:       return '0;
      3:       return CoefBits'(int'($urandom_range(0, 64)) - 32);
      default: return CoefBits'($urandom());
    endcase
  endfunction

  // occupancy often lands on or next to the current threshold
  function automatic logic [OccBits-1:0] pick_occupancy();
    case ($urandom_range(0, 7))
      0:       return threshold_now;
      1:       return threshold_now + 1'b1;
      2:       return threshold_now - 1'b1;
      3:       return '0;
      4:       return '1;
      default: return OccBits'($urandom());
    endcase
  endfunction

  function automatic logic [WgtBits-1:0] pick_weight();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      default: return WgtBits'($urandom());
    endcase
  endfunction

  // offer one transaction and hold it until accepted
  task automatic send_wave(input wave_item_t w);
    in_valid      <= 1'b1;
    proj_re       <= w.proj_re;
    proj_im       <= w.proj_im;
    ref_re        <= w.ref_re;
    ref_im        <= w.ref_im;
    last_wave     <= w.last_wave;
    occupancy     <= w.occupancy;
    kpoint_weight <= w.kpoint_weight;
    clear_totals  <= w.clear_totals;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  // random sender gap
  task automatic pause_sender();
    if (!quiet_tail && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
  endtask

  task automatic write_threshold(input logic [OccBits-1:0] value);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(negedge clk);
    cfg_we        <= 1'b0;
    threshold_now  = value;
  endtask

  // wait for every predicted result, then let the pipeline empty
  task automatic settle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  // one band of random length, clears sprinkled anywhere in it
  task automatic send_band(input int len);
    wave_item_t w;
    for (int i = 0; i < len; i++) begin
      w = make_wave(pick_coef(), pick_coef(), pick_coef(), pick_coef(), i == len - 1,
                    pick_occupancy(), pick_weight(), $urandom_range(0, 15) == 0);
      pause_sender();
      send_wave(w);
    end
  endtask

  // band longer than the accumulators can hold, fixed extreme coefficients
  task automatic send_long_band(input logic signed [CoefBits-1:0] pr,
                                input logic signed [CoefBits-1:0] pi,
                                input logic signed [CoefBits-1:0] rr,
                                input logic signed [CoefBits-1:0] ri);
    for (int i = 0; i < LongBandLen; i++) begin
      pause_sender();
      send_wave(make_wave(pr, pi, rr, ri, i == LongBandLen - 1, pick_occupancy(), '1, 1'b0));
    end
  endtask

  task automatic run_phase(input int target);
    int start;
    start = items_sent;
    while (items_sent - start < target) begin
      if ($urandom_range(0, 9) == 0) begin
        send_band($urandom_range(9, 40));
      end else begin
        send_band($urandom_range(1, 8));
      end
    end
  endtask

  // receiver: ready bursts, one long hold-off on request, always ready in the tail
  initial begin : receiver
    bit level;
    int span;
    out_ready = 1'b0;
    @(negedge clk);
    forever begin
      if (stall_request) begin
        stall_request = 1'b0;
        level         = 1'b0;
        span          = StallCycles;
      end else if (quiet_tail) begin
        level = 1'b1;
        span  = 1;
      end else if ($urandom_range(0, 3) == 0) begin
        level = 1'b0;
        span  = $urandom_range(1, 10);
      end else begin
        level = 1'b1;
        span  = $urandom_range(1, 20);
      end
      out_ready <= level;
      repeat (span) @(negedge clk);
    end
  end

  // stimulus and verdict
  initial begin : stimulus
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_data      = '0;
    in_valid      = 1'b0;
    proj_re       = '0;
    proj_im       = '0;
    ref_re        = '0;
    ref_im        = '0;
    last_wave     = 1'b0;
    occupancy     = '0;
    kpoint_weight = '0;
    clear_totals  = 1'b0;
    quiet_tail    = 1'b0;
    stall_request = 1'b0;
    items_sent    = 0;
    threshold_now = ThreshReset;
    repeat (ResetCycles) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed bands at the reset threshold
    // all positive extremes, just above threshold
    send_wave(make_wave(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b1,
                        threshold_now + 1'b1, '1, 1'b0));
    // all negative extremes, real part saturates, occupancy equal to threshold
    send_wave(make_wave(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 1'b1,
                        threshold_now, '1, 1'b0));
    // two waves driving the real part below the overlap range
    send_wave(make_wave(16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 1'b0, '0, '0, 1'b0));
    send_wave(make_wave(16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 1'b1, '1, '1, 1'b0));
    // clear alone, unused fields at their maximum
    send_wave(make_wave('0, '0, '0, '0, 1'b0, '1, '1, 1'b1));
    // clear together with a last wave
    send_wave(make_wave(16'sh3039, -16'sh1a2b, 16'sh0fed, 16'sh4c4c, 1'b1, '0, 16'd40000,
                        1'b1));
    // two waves driving the imaginary part above the overlap range, zero weight
    send_wave(make_wave(16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b0, '1, '1, 1'b0));
    send_wave(make_wave(16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b1,
                        threshold_now - 1'b1, '0, 1'b0));
    // all zero
    send_wave(make_wave('0, '0, '0, '0, 1'b1, '0, '0, 1'b0));
    // smallest nonzero products, full weight and then unit weight
    send_wave(make_wave(16'sd1, '0, 16'sd1, '0, 1'b1, '1, '1, 1'b0));
    send_wave(make_wave('0, -16'sd1, 16'sd1, '0, 1'b1, '1, 16'd1, 1'b0));
    // three mixed waves
    send_wave(make_wave(16'sh1234, -16'sh4321, 16'sh7000, -16'sh0800, 1'b0, '0, '0, 1'b0));
    send_wave(make_wave(-16'sh7ff0, 16'sh2222, -16'sh0101, 16'sh5a5a, 1'b0, '0, '0, 1'b0));
    send_wave(make_wave(16'sh0ace, 16'sh7777, -16'sh6000, -16'sh3333, 1'b1,
                        threshold_now + 1'b1, 16'd1, 1'b0));
    settle();

    // threshold zero, random bands
    write_threshold('0);
    run_phase(PhaseItems);
    settle();

    // threshold at its maximum, with a long output stall while the sender keeps going
    write_threshold('1);
    stall_request = 1'b1;
    run_phase(PhaseItems);
    settle();

    // random threshold, real accumulator saturates upward
    write_threshold(OccBits'($urandom()));
    send_long_band(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    run_phase(PhaseItems);
    settle();

    // quarter threshold, imaginary accumulator saturates downward
    write_threshold(16'd4096);
    send_long_band(16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh7fff);
    run_phase(PhaseItems);
    settle();

    // back to default, no idling on either side
    write_threshold(ThreshReset);
    quiet_tail = 1'b1;
    run_phase(PhaseItems);
    settle();

    $display("summary: %0d coefficient transactions in, %0d overlap results checked",
             items_sent, results);
    $display("summary: thresholds reset, min, max, random, quarter; saturating bands; %0d-cycle stall",
             StallCycles);
    if (mismatches == 0 && pending == 0) begin
      $display("band_overlap_projector_tb: done, clean");
    end else begin
      $display("band_overlap_projector_tb: done, errors");
    end
    $finish;
  end

endmodule

/* band_overlap_projector.f */
src/bop_pkg.sv
src/bop_ctrl.sv
src/bop_datapath.sv
src/band_overlap_projector.sv
tb/sv/band_overlap_projector_monitor.sv
tb/sv/band_overlap_projector_tb.sv
